### rtl/rpp_pkg.sv
// Package for the replay packet pacer: payload structs, command and result codes,
// and the queue depth shared by the pipeline modules.
// Depends on nothing; every rtl module imports it.
package rpp_pkg;

    localparam int OUT_TIME_W  = 56;
    localparam int BYTES_W     = 40;
    localparam int LEN_W       = 16;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // Commands carried by an input transaction.
    localparam logic [1:0] CMD_PACKET  = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_SECOND  = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Kinds of result transaction.
    localparam logic [1:0] KIND_RELEASED = 2'd0;
    localparam logic [1:0] KIND_REPORT   = 2'd1;
    localparam logic [1:0] KIND_REFUSED  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_SPEED_FACTOR = 1'b0;
    localparam logic REG_BIT_LIMIT    = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [31:0]      ts_sec;
        logic [19:0]      ts_usec;
        logic [LEN_W-1:0] pkt_len;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [LEN_W-1:0]      out_len;
        logic [OUT_TIME_W-1:0] out_time_us;
        logic [BYTES_W-1:0]    report_bytes;
        logic                  last_of_run;
    } t_out_item;

    // Results produced by one input item and pushed together, zero to two of them.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

endpackage

### rtl/replay_packet_pacer.sv
// Replay packet pacer: releases, holds or refuses packets against a virtual send clock.
// Accepted transactions pass the input and conversion registers into the core.
// Throughput: one input transaction per cycle while the result queue has room; a
// one-second tick that also frees the held packet gives two results, which leave in turn.
// Reset (i_rst_n low at a clock edge) clears the clock, the byte window, the held
// packet, the result queue, and restores real-time speed with no bit limit.
module replay_packet_pacer #(
    parameter int TICK_PERIOD_US = 100000,
    parameter int TIME_BITS      = 56
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rpp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rpp_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rpp_pkg::BYTES_W-1:0]   i_cfg_data
);
    import rpp_pkg::*;

    // The pipeline has three steps. The first register holds the accepted
    // transaction; the timestamp is turned into microseconds on the way to the
    // second register. The core then updates the pacing state in that same cycle
    // and writes zero, one or two results into the output queue.
    //
    // The two pipeline stages never stall. Instead, a transaction is accepted only
    // when the queue has room for two results from it and from every transaction
    // still in the stages, so nothing can overflow. The queue depth of eight keeps
    // acceptance going every cycle while the consumer keeps up, and the queue also
    // lets new input be taken while a finished result waits on the output side.

    localparam int RES_W = OUTQ_CNT_W + 1;

    logic                       accept;
    logic                       a_valid;
    logic                       b_valid;
    logic [1:0]                 b_cmd;
    logic [LEN_W-1:0]           b_len;
    logic [TIME_BITS-1:0]       b_time;
    t_push                      push;
    logic [OUTQ_CNT_W-1:0]      q_count;
    logic [RES_W-1:0]           reserved;

    // Each stage in flight reserves two queue entries, as does the new transaction.
    assign reserved   = RES_W'(q_count)
                        + RES_W'({({1'b0, a_valid} + {1'b0, b_valid}), 1'b0})
                        + RES_W'(2);
    // Nothing is taken while reset is held.
    assign o_in_ready = i_rst_n && (reserved <= RES_W'(OUTQ_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    rpp_ts_conv #(
        .TIME_BITS (TIME_BITS)
    ) u_ts_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_data),
        .o_a_valid (a_valid),
        .o_b_valid (b_valid),
        .o_b_cmd   (b_cmd),
        .o_b_len   (b_len),
        .o_b_time  (b_time)
    );

    // Configuration writes must arrive only while the block is idle; the block does not
    // enforce this, and the writes go straight into the core's registers.
    rpp_core #(
        .TICK_PERIOD_US (TICK_PERIOD_US),
        .TIME_BITS      (TIME_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_b_valid  (b_valid),
        .i_b_cmd    (b_cmd),
        .i_b_len    (b_len),
        .i_b_time   (b_time),
        .o_push     (push)
    );

    rpp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data),
        .o_count (q_count)
    );

endmodule

### rtl/rpp_ts_conv.sv
// Input register and timestamp conversion stage of the replay packet pacer.
// Turns seconds and microseconds into one microsecond count; uses rpp_pkg.
module rpp_ts_conv #(
    parameter int TIME_BITS = 56
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  rpp_pkg::t_in_item           i_item,
    output logic                        o_a_valid,
    output logic                        o_b_valid,
    output logic [1:0]                  o_b_cmd,
    output logic [rpp_pkg::LEN_W-1:0]   o_b_len,
    output logic [TIME_BITS-1:0]        o_b_time
);
    import rpp_pkg::*;

    logic                 r_a_valid;
    t_in_item             r_a;
    logic                 r_b_valid;
    logic [1:0]           r_b_cmd;
    logic [LEN_W-1:0]     r_b_len;
    logic [TIME_BITS-1:0] r_b_time;

    logic [51:0] sec_us;
    logic [52:0] full_us;

    // Constant multiplier; synthesis reduces it to a few shifted adds.
    assign sec_us  = r_a.ts_sec * USEC_PER_SEC;
    assign full_us = {1'b0, sec_us} + {33'd0, r_a.ts_usec};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
        end
        if (i_accept) begin
            r_a <= i_item;
        end
        r_b_cmd  <= r_a.cmd;
        r_b_len  <= r_a.pkt_len;
        r_b_time <= TIME_BITS'(full_us);
    end

    assign o_a_valid = r_a_valid;
    assign o_b_valid = r_b_valid;
    assign o_b_cmd   = r_b_cmd;
    assign o_b_len   = r_b_len;
    assign o_b_time  = r_b_time;

endmodule

### rtl/rpp_core.sv
// Pacing state machine of the replay packet pacer: virtual clock, byte window,
// held packet and configuration. Produces up to two results per item; uses rpp_pkg.
module rpp_core #(
    parameter int TICK_PERIOD_US = 100000,
    parameter int TIME_BITS      = 56
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rpp_pkg::BYTES_W-1:0]   i_cfg_data,
    input  logic                          i_b_valid,
    input  logic [1:0]                    i_b_cmd,
    input  logic [rpp_pkg::LEN_W-1:0]     i_b_len,
    input  logic [TIME_BITS-1:0]          i_b_time,
    output rpp_pkg::t_push                o_push
);
    import rpp_pkg::*;

    localparam int TICK_W = $clog2(TICK_PERIOD_US + 1);
    localparam int INC_W  = TICK_W + 8;

    logic [INC_W-1:0]     r_tick_inc;
    logic [BYTES_W-1:0]   r_bit_limit;
    logic                 r_started;
    logic [TIME_BITS-1:0] r_next;
    logic [BYTES_W-1:0]   r_window;
    logic [TIME_BITS-1:0] r_last;
    logic                 r_held;
    logic [TIME_BITS-1:0] r_held_time;
    logic [LEN_W-1:0]     r_held_len;

    logic                 n_started;
    logic [TIME_BITS-1:0] n_next;
    logic [BYTES_W-1:0]   n_window;
    logic [TIME_BITS-1:0] n_last;
    logic                 n_held;
    logic                 n_hold_new;

    logic [TICK_W+15:0]   inc_prod;
    logic [TIME_BITS:0]   adv_sum;
    logic [TIME_BITS-1:0] adv_next;
    logic [TIME_BITS-1:0] cand_time;
    logic [LEN_W-1:0]     cand_len;
    logic [BYTES_W-1:0]   add_base;
    logic [BYTES_W:0]     add_sum;
    logic [BYTES_W-1:0]   sat_window;
    logic                 limit_ok;
    logic                 time_ok;
    logic [63:0]          cand_time_64;
    logic [63:0]          last_64;
    t_out_item            rel_item;
    t_out_item            rep_item;
    t_out_item            ref_item;
    t_push                push;

    assign inc_prod = TICK_W'(TICK_PERIOD_US) * i_cfg_data[15:0];

    // Saturating advance of the virtual clock by one tick.
    assign adv_sum  = {1'b0, r_next} + (TIME_BITS + 1)'(r_tick_inc);
    assign adv_next = adv_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : adv_sum[TIME_BITS-1:0];

    // The candidate for release is the new packet or else the held one.
    assign cand_time = (i_b_cmd == CMD_PACKET) ? i_b_time : r_held_time;
    assign cand_len  = (i_b_cmd == CMD_PACKET) ? i_b_len : r_held_len;
    assign add_base  = (i_b_cmd == CMD_SECOND) ? '0 : r_window;
    assign add_sum   = {1'b0, add_base} + (BYTES_W + 1)'(cand_len);
    assign sat_window = add_sum[BYTES_W] ? {BYTES_W{1'b1}} : add_sum[BYTES_W-1:0];

    // A cleared window always passes the limit, so the second tick skips the check.
    assign limit_ok = (i_b_cmd == CMD_SECOND) || (r_bit_limit == '0) ||
                      ({r_window, 3'b000} <= {3'b000, r_bit_limit});
    assign time_ok  = (cand_time <= n_next);

    assign cand_time_64 = 64'(cand_time);
    assign last_64      = 64'(r_last);

    always_comb begin
        rel_item = '{result_kind: KIND_RELEASED, out_len: cand_len,
                     out_time_us: cand_time_64[OUT_TIME_W-1:0], report_bytes: '0,
                     last_of_run: 1'b1};
        rep_item = '{result_kind: KIND_REPORT, out_len: '0,
                     out_time_us: last_64[OUT_TIME_W-1:0], report_bytes: r_window,
                     last_of_run: 1'b1};
        ref_item = '{result_kind: KIND_REFUSED, out_len: i_b_len,
                     out_time_us: '0, report_bytes: '0, last_of_run: 1'b1};
    end

    always_comb begin
        n_started  = r_started;
        n_next     = r_next;
        n_window   = r_window;
        n_last     = r_last;
        n_held     = r_held;
        n_hold_new = 1'b0;
        push       = '{count: 2'd0, first: rel_item, second: rel_item};

        unique case (i_b_cmd)
            CMD_PACKET: begin
                if (r_held) begin
                    push.count = 2'd1;
                    push.first = ref_item;
                end else begin
                    n_started = 1'b1;
                    if (!r_started) begin
                        n_next = i_b_time;
                    end
                    if (time_ok && limit_ok) begin
                        n_window   = sat_window;
                        n_last     = i_b_time;
                        push.count = 2'd1;
                    end else begin
                        n_held     = 1'b1;
                        n_hold_new = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                if (r_started) begin
                    n_next = adv_next;
                end
                if (r_held && time_ok && limit_ok) begin
                    n_held     = 1'b0;
                    n_window   = sat_window;
                    n_last     = r_held_time;
                    push.count = 2'd1;
                end
            end
            CMD_SECOND: begin
                push.count = 2'd1;
                push.first = rep_item;
                n_window   = '0;
                if (r_held && time_ok) begin
                    push.first.last_of_run = 1'b0;
                    push.count = 2'd2;
                    n_held     = 1'b0;
                    n_window   = sat_window;
                    n_last     = r_held_time;
                end
            end
            CMD_RESTART: begin
                n_started = 1'b0;
                n_next    = '0;
                n_last    = '0;
                if (r_held) begin
                    // The held packet restarts the clock at its own timestamp.
                    n_started = 1'b1;
                    n_next    = r_held_time;
                    if (limit_ok) begin
                        n_held     = 1'b0;
                        n_window   = sat_window;
                        n_last     = r_held_time;
                        push.count = 2'd1;
                    end
                end
            end
        endcase

        if (!i_b_valid) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc  <= INC_W'(TICK_PERIOD_US);
            r_bit_limit <= '0;
            r_started   <= 1'b0;
            r_next      <= '0;
            r_window    <= '0;
            r_last      <= '0;
            r_held      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SPEED_FACTOR: r_tick_inc  <= inc_prod[TICK_W+15:8];
                    REG_BIT_LIMIT:    r_bit_limit <= i_cfg_data;
                endcase
            end
            if (i_b_valid) begin
                r_started <= n_started;
                r_next    <= n_next;
                r_window  <= n_window;
                r_last    <= n_last;
                r_held    <= n_held;
            end
        end
        if (i_b_valid && n_hold_new) begin
            r_held_time <= i_b_time;
            r_held_len  <= i_b_len;
        end
    end

    assign o_push = push;

endmodule

### rtl/rpp_out_fifo.sv
// Result queue of the replay packet pacer: takes up to two results a cycle and
// offers one per output transaction. Uses rpp_pkg.
module rpp_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rpp_pkg::t_push                     i_push,
    output logic                               o_valid,
    input  logic                               i_ready,
    output rpp_pkg::t_out_item                 o_item,
    output logic [rpp_pkg::OUTQ_CNT_W-1:0]     o_count
);
    import rpp_pkg::*;

    t_out_item               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]   r_rd_ptr;
    logic [OUTQ_CNT_W-1:0]   r_count;

    logic                    pop;
    logic [OUTQ_PTR_W-1:0]   wr_ptr_1;

    assign pop      = (r_count != '0) && i_ready;
    assign wr_ptr_1 = r_wr_ptr + OUTQ_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(pop);
            r_count  <= r_count + OUTQ_CNT_W'(i_push.count) - OUTQ_CNT_W'(pop);
        end
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the replay packet pacer: directed and random transactions,
// a built-in model of the send clock, byte window and held packet, and a result checker.
// Depends on rtl/rpp_pkg.sv and rtl/replay_packet_pacer.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpp_pkg::*;

    // The block's default tick period; the instance below keeps its default parameters.
    localparam int unsigned TICK_US = 100000;
    localparam logic [OUT_TIME_W-1:0] TIME_MAX = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    // Margin for a transaction to pass the pipeline registers and reach the result queue.
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 480;

    // Every input of the block starts at a known value.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_idx = REG_SPEED_FACTOR;
    logic [BYTES_W-1:0]   i_cfg_data = '0;

    // Model of the pacer: configuration, virtual send clock, byte window, held packet.
    logic [15:0]           cfg_speed;
    logic [BYTES_W-1:0]    cfg_bit_limit;
    bit                    pace_running;
    logic [OUT_TIME_W-1:0] send_clock_us;
    logic [BYTES_W-1:0]    window_byte_count;
    logic [OUT_TIME_W-1:0] last_sent_us;
    bit                    parked_valid;
    logic [OUT_TIME_W-1:0] parked_us;
    logic [LEN_W-1:0]      parked_len;

    // Results of the transaction being modeled, and all results still owed by the block.
    t_out_item step_results[$];
    t_out_item awaited_results[$];

    // Stall control for both channels; a calm count forces a stretch with no idling.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          send_calm = 0;
    int          recv_calm = 0;

    // Capture-time cursor that keeps random packets in a plausible replay order.
    longint unsigned replay_cursor_us;

    int items_sent = 0;
    int mismatches = 0;
    int released_seen = 0;
    int reports_seen = 0;
    int refused_seen = 0;

    replay_packet_pacer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pacer model
    // ------------------------------------------------------------------

    task automatic pace_reset();
        cfg_speed = 16'd256;
        cfg_bit_limit = '0;
        pace_running = 1'b0;
        send_clock_us = '0;
        window_byte_count = '0;
        last_sent_us = '0;
        parked_valid = 1'b0;
        parked_us = '0;
        parked_len = '0;
    endtask

    function automatic t_out_item make_result(logic [1:0] kind, logic [LEN_W-1:0] len,
                                              logic [OUT_TIME_W-1:0] t,
                                              logic [BYTES_W-1:0] bytes);
        t_out_item r;
        r.result_kind = kind;
        r.out_len = len;
        r.out_time_us = t;
        r.report_bytes = bytes;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // A packet may leave when its time has come and the window is not over the bit limit.
    function automatic bit rate_allows(logic [OUT_TIME_W-1:0] t);
        logic [63:0] window_bits;
        window_bits = {21'b0, window_byte_count, 3'b000};
        if (t > send_clock_us)
            return 1'b0;
        if (cfg_bit_limit != '0 && window_bits > {24'b0, cfg_bit_limit})
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic record_send(input logic [OUT_TIME_W-1:0] t, input logic [LEN_W-1:0] len);
        logic [BYTES_W:0] sum;
        sum = {1'b0, window_byte_count} + {25'b0, len};
        last_sent_us = t;
        window_byte_count = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
    endtask

    task automatic release_parked();
        if (parked_valid && rate_allows(parked_us)) begin
            parked_valid = 1'b0;
            record_send(parked_us, parked_len);
            step_results.push_back(make_result(KIND_RELEASED, parked_len, parked_us, '0));
        end
    endtask

    // Works out the results of one accepted input transaction and queues them.
    task automatic pace_step(input t_in_item item);
        logic [63:0]           stamp;
        logic [63:0]           step_us;
        logic [63:0]           headroom;
        logic [OUT_TIME_W-1:0] t;
        step_results.delete();
        stamp = {32'b0, item.ts_sec} * 64'd1000000 + {44'b0, item.ts_usec};
        t = stamp[OUT_TIME_W-1:0];
        case (item.cmd)
            CMD_PACKET: begin
                if (parked_valid) begin
                    step_results.push_back(make_result(KIND_REFUSED, item.pkt_len, '0, '0));
                end else begin
                    if (!pace_running) begin
                        pace_running = 1'b1;
                        send_clock_us = t;
                    end
                    if (rate_allows(t)) begin
                        record_send(t, item.pkt_len);
                        step_results.push_back(make_result(KIND_RELEASED, item.pkt_len, t, '0));
                    end else begin
                        parked_valid = 1'b1;
                        parked_us = t;
                        parked_len = item.pkt_len;
                    end
                end
            end
            CMD_TICK: begin
                if (pace_running) begin
                    step_us = ({48'b0, cfg_speed} * TICK_US) >> 8;
                    headroom = {8'b0, TIME_MAX - send_clock_us};
                    if (step_us > headroom)
                        send_clock_us = TIME_MAX;
                    else
                        send_clock_us = send_clock_us + step_us[OUT_TIME_W-1:0];
                end
                release_parked();
            end
            CMD_SECOND: begin
                step_results.push_back(make_result(KIND_REPORT, '0, last_sent_us,
                                                   window_byte_count));
                window_byte_count = '0;
                release_parked();
            end
            CMD_RESTART: begin
                pace_running = 1'b0;
                send_clock_us = '0;
                last_sent_us = '0;
                if (parked_valid) begin
                    pace_running = 1'b1;
                    send_clock_us = parked_us;
                    release_parked();
                end
            end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        foreach (step_results[i])
            awaited_results.push_back(step_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Driving the block
    // ------------------------------------------------------------------

    // Offers one input transaction at a falling edge, after a random gap, and holds it
    // until a rising edge sees valid and ready together. Valid stays high on return so
    // that back-to-back transactions never lower and raise it in the same time step.
    task automatic send_item(input t_in_item item);
        @(negedge i_clk);
        if (send_calm > 0) begin
            send_calm--;
        end else if ($urandom_range(63) == 0) begin
            send_calm = 40;
        end else begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pace_step(item);
        items_sent++;
    endtask

    task automatic send_fields(input logic [1:0] cmd, input logic [31:0] sec,
                               input logic [19:0] usec, input logic [LEN_W-1:0] len);
        t_in_item item;
        item.cmd = cmd;
        item.ts_sec = sec;
        item.ts_usec = usec;
        item.pkt_len = len;
        send_item(item);
    endtask

    task automatic sender_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Waits until every owed result has come, then lets the pipeline settle, since a
    // held packet leaves no result behind to wait for.
    task automatic wait_drained();
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic program_pacer(input logic [15:0] speed, input logic [BYTES_W-1:0] limit);
        sender_quiet();
        wait_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_SPEED_FACTOR;
        i_cfg_data <= {24'b0, speed};
        @(posedge i_clk);
        cfg_speed = speed;
        @(negedge i_clk);
        i_cfg_idx <= REG_BIT_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        cfg_bit_limit = limit;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // The receiver stalls at random, with occasional stretches of steady readiness.
    always @(negedge i_clk) begin
        if (recv_calm > 0) begin
            recv_calm--;
            i_out_ready <= 1'b1;
        end else begin
            if ($urandom_range(63) == 0)
                recv_calm = 40;
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Each result transaction is matched against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("result_kind", 64'(want.result_kind),
                              64'(o_out_data.result_kind));
                compare_field("out_len", 64'(want.out_len), 64'(o_out_data.out_len));
                compare_field("out_time_us", 64'(want.out_time_us),
                              64'(o_out_data.out_time_us));
                compare_field("report_bytes", 64'(want.report_bytes),
                              64'(o_out_data.report_bytes));
                compare_field("last_of_run", 64'(want.last_of_run),
                              64'(o_out_data.last_of_run));
                case (want.result_kind)
                    KIND_RELEASED: released_seen++;
                    KIND_REPORT:   reports_seen++;
                    default:       refused_seen++;
                endcase
            end
        end
    end

    // Ends the run if no transaction of any kind happens for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: %0d cycles without a transaction", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: real-time speed and no limit. Covers a tick before the clock has
    // started, an empty report, the first packet setting the clock, a held packet,
    // a refusal while holding, and a tick that releases the held packet.
    task automatic test_reset_defaults();
        send_fields(CMD_TICK, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_SECOND, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_PACKET, 32'd5, 20'd0, 16'd0);
        send_fields(CMD_PACKET, 32'd5, 20'd100000, 16'hFFFF);
        send_fields(CMD_PACKET, 32'd5, 20'd0, 16'd1);
        send_fields(CMD_TICK, 32'd0, 20'd0, 16'd0);
    endtask

    // Largest timestamp fields, with microseconds past one second, are held; a report
    // leaves the packet held; restart then treats it as the first packet. A restart
    // with nothing held and a zero timestamp packet follow.
    task automatic test_restart_and_extremes();
        send_fields(CMD_PACKET, 32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF);
        send_fields(CMD_SECOND, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_RESTART, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_RESTART, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_PACKET, 32'd0, 20'd0, 16'd0);
    endtask

    // Zero speed keeps the clock still and a tiny bit limit holds packets until the
    // one-second tick, which then gives a report followed by the release. Maximum speed
    // and limit follow.
    task automatic test_speed_and_limit();
        program_pacer(16'd0, 40'd8);
        send_fields(CMD_PACKET, 32'd7, 20'd0, 16'd2);
        send_fields(CMD_TICK, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_RESTART, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_SECOND, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_PACKET, 32'd7, 20'd0, 16'd1);
        send_fields(CMD_PACKET, 32'd6, 20'd0, 16'd3);
        send_fields(CMD_SECOND, 32'd0, 20'd0, 16'd0);
        program_pacer(16'hFFFF, BYTES_MAX);
        send_fields(CMD_PACKET, 32'd9, 20'd0, 16'hFFFF);
        send_fields(CMD_TICK, 32'd0, 20'd0, 16'd0);
        send_fields(CMD_PACKET, 32'd30, 20'd999999, 16'd100);
    endtask

    // Mostly a plausible capture stream with random lengths and gaps; some packets come
    // out of order, and about one transaction in ten is fully random.
    task automatic random_replay_item(output t_in_item item);
        int unsigned pick;
        pick = $urandom_range(99);
        item = '0;
        item.pkt_len = LEN_W'($urandom_range(16'hFFFF));
        if (pick < 58) begin
            if ($urandom_range(19) == 0 && replay_cursor_us > 50000)
                replay_cursor_us -= 64'($urandom_range(50000));
            else
                replay_cursor_us += 64'($urandom_range(40000));
            item.cmd = CMD_PACKET;
            item.ts_sec = 32'(replay_cursor_us / 1000000);
            item.ts_usec = 20'(replay_cursor_us % 1000000);
        end else if (pick < 78) begin
            item.cmd = CMD_TICK;
        end else if (pick < 86) begin
            item.cmd = CMD_SECOND;
        end else if (pick < 90) begin
            item.cmd = CMD_RESTART;
            replay_cursor_us = longint'($urandom_range(32'hFFFF0000)) * 1000000;
        end else begin
            item.cmd = 2'($urandom_range(3));
            item.ts_sec = $urandom;
            item.ts_usec = 20'($urandom_range(20'hFFFFF));
        end
    endtask

    // One random phase under one configuration; halfway through, the sender waits for
    // every owed result before going on.
    task automatic test_random_replay(input int count, input logic [15:0] speed,
                                      input logic [BYTES_W-1:0] limit);
        t_in_item item;
        program_pacer(speed, limit);
        replay_cursor_us = longint'($urandom_range(4000)) * 1000000;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                sender_quiet();
                wait_drained();
            end
            random_replay_item(item);
            send_item(item);
        end
        sender_quiet();
    endtask

    initial begin
        pace_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct = 27;
        recv_idle_pct = 84;
        test_reset_defaults();
        test_restart_and_extremes();
        test_speed_and_limit();
        test_random_replay(RANDOM_ITEMS, 16'd256, 40'($urandom_range(4000000, 1000000)));

        // Sender idles heavily, receiver stalls lightly.
        send_idle_pct = 84;
        recv_idle_pct = 27;
        test_random_replay(RANDOM_ITEMS, 16'hFFFF, BYTES_MAX);

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_replay(RANDOM_ITEMS, 16'($urandom_range(1024, 128)), '0);

        wait_drained();
        $display("Summary: %0d input transactions over three stall profiles and several",
                 items_sent);
        $display("speed and limit settings; %0d releases, %0d reports, %0d refusals checked.",
                 released_seen, reports_seen, refused_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/rpp_pkg.sv
rtl/rpp_ts_conv.sv
rtl/rpp_core.sv
rtl/rpp_out_fifo.sv
rtl/replay_packet_pacer.sv
sim/tb_top.sv
